// File: hdl/qtoe_pkg.sv
package qtoe_pkg;

    // Default number of CORDIC micro-rotations and the largest supported.
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    // Widths of the internal data paths.
    localparam int PW     = 32;  // one 16x16 product
    localparam int SW     = 30;  // saturated asin argument, +-2^28
    localparam int CW     = 36;  // CORDIC coordinates, 2^28 = 1.0
    localparam int ZW     = 27;  // angle accumulator, 1/65536 degree
    localparam int RW     = 58;  // square root radicand and partial root
    localparam int ROOT_W = 29;  // square root result, at most 2^28

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [ZW-1:0] angle_t;

    // Data that rides along the square root pipeline.
    typedef struct packed {
        logic signed [SW-1:0] s;
        logic                 clamp;
        coord_t               roll_y;
        coord_t               roll_x;
        coord_t               yaw_y;
        coord_t               yaw_x;
    } side_t;

    localparam angle_t HALF_TURN = 27'sd11796480;

    // atan(2^-i) in 1/65536 degree, rounded to nearest.
    function automatic angle_t atan_deg(input int i);
        angle_t a;
        case (i)
            0:       a = 27'sd2949120;
            1:       a = 27'sd1740967;
            2:       a = 27'sd919879;
            3:       a = 27'sd466945;
            4:       a = 27'sd234379;
            5:       a = 27'sd117304;
            6:       a = 27'sd58666;
            7:       a = 27'sd29335;
            8:       a = 27'sd14668;
            9:       a = 27'sd7334;
            10:      a = 27'sd3667;
            11:      a = 27'sd1833;
            12:      a = 27'sd917;
            13:      a = 27'sd458;
            14:      a = 27'sd229;
            15:      a = 27'sd115;
            16:      a = 27'sd57;
            17:      a = 27'sd29;
            18:      a = 27'sd14;
            19:      a = 27'sd7;
            20:      a = 27'sd4;
            21:      a = 27'sd2;
            22:      a = 27'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// File: hdl/qtoe_front.sv
module qtoe_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [15:0]   quat_w,
    input  logic signed [15:0]   quat_x,
    input  logic signed [15:0]   quat_y,
    input  logic signed [15:0]   quat_z,
    output logic                 out_valid,
    output logic [qtoe_pkg::RW-1:0] rad,
    output qtoe_pkg::side_t      side
);
    import qtoe_pkg::*;

    localparam logic signed [33:0] ONE_S = 34'sd268435456;
    localparam coord_t             ONE_C = CW'(34'sd268435456);
    localparam logic [RW-1:0]      FULL  = RW'(1) << 56;

    // Stage 1: products.
    logic                 v1_reg;
    logic signed [PW-1:0] wx_reg, yz_reg, wy_reg, zx_reg, wz_reg, xy_reg;
    logic signed [PW-1:0] xx_reg, yy_reg, zz_reg;

    // Stage 2: sums and the saturated asin argument.
    logic                 v2_reg;
    side_t                side2_reg, side2_next;
    logic signed [33:0]   s_sum, s_full, d_roll, d_yaw, n_roll, n_yaw;

    // Stage 3: square of the argument.
    logic                 v3_reg;
    side_t                side3_reg;
    logic [RW-1:0]        sq_reg;
    logic signed [2*SW-1:0] sq_full;

    // Stage 4: radicand.
    logic                 v4_reg;
    side_t                side4_reg;
    logic [RW-1:0]        rad_reg;

    always_comb
    begin
        s_sum  = 34'(wx_reg) + 34'(yz_reg);
        s_full = s_sum <<< 1;
        d_roll = 34'(wy_reg) - 34'(zx_reg);
        d_yaw  = 34'(wz_reg) + 34'(xy_reg);
        n_roll = 34'(xx_reg) + 34'(yy_reg);
        n_yaw  = 34'(yy_reg) + 34'(zz_reg);

        side2_next.clamp = 1'b0;
        if (s_full > ONE_S)
        begin
            side2_next.s     = SW'(ONE_S);
            side2_next.clamp = 1'b1;
        end
        else if (s_full < -ONE_S)
        begin
            side2_next.s     = SW'(-ONE_S);
            side2_next.clamp = 1'b1;
        end
        else
        begin
            side2_next.s = SW'(s_full);
        end
        side2_next.roll_y = CW'(d_roll) <<< 1;
        side2_next.roll_x = ONE_C - (CW'(n_roll) <<< 1);
        side2_next.yaw_y  = CW'(d_yaw) <<< 1;
        side2_next.yaw_x  = ONE_C - (CW'(n_yaw) <<< 1);
        sq_full           = side2_reg.s * side2_reg.s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg    <= quat_w * quat_x;
        yz_reg    <= quat_y * quat_z;
        wy_reg    <= quat_w * quat_y;
        zx_reg    <= quat_z * quat_x;
        wz_reg    <= quat_w * quat_z;
        xy_reg    <= quat_x * quat_y;
        xx_reg    <= quat_x * quat_x;
        yy_reg    <= quat_y * quat_y;
        zz_reg    <= quat_z * quat_z;
        side2_reg <= side2_next;
        sq_reg    <= RW'(sq_full);
        side3_reg <= side2_reg;
        rad_reg   <= FULL - sq_reg;
        side4_reg <= side3_reg;
    end

    assign out_valid = v4_reg;
    assign rad       = rad_reg;
    assign side      = side4_reg;

endmodule

// File: hdl/qtoe_isqrt.sv
module qtoe_isqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [qtoe_pkg::RW-1:0]  rad,
    input  qtoe_pkg::side_t          side_in,
    output logic                     out_valid,
    output logic [qtoe_pkg::ROOT_W-1:0] root,
    output qtoe_pkg::side_t          side_out
);
    import qtoe_pkg::*;

    // One root bit per stage, most significant first.
    logic [RW-1:0] n_reg   [ROOT_W];
    logic [RW-1:0] res_reg [ROOT_W];
    logic          v_reg   [ROOT_W];
    side_t         side_reg[ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_bit
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (ROOT_W - 1 - j));
        logic [RW-1:0] n_in, res_in, n_next, res_next;
        logic          v_in;
        side_t         side_cur;

        if (j == 0)
        begin : g_first
            assign n_in     = rad;
            assign res_in   = '0;
            assign v_in     = in_valid;
            assign side_cur = side_in;
        end
        else
        begin : g_rest
            assign n_in     = n_reg[j-1];
            assign res_in   = res_reg[j-1];
            assign v_in     = v_reg[j-1];
            assign side_cur = side_reg[j-1];
        end

        always_comb
        begin
            if (n_in >= res_in + BIT)
            begin
                n_next   = n_in - (res_in + BIT);
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[j]    <= n_next;
            res_reg[j]  <= res_next;
            side_reg[j] <= side_cur;
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign root      = res_reg[ROOT_W-1][ROOT_W-1:0];
    assign side_out  = side_reg[ROOT_W-1];

endmodule

// File: hdl/qtoe_cordic.sv
module qtoe_cordic #(
    parameter int STAGES = qtoe_pkg::CORDIC_STAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  qtoe_pkg::coord_t  y_in,
    input  qtoe_pkg::coord_t  x_in,
    output logic              out_valid,
    output qtoe_pkg::angle_t  angle
);
    import qtoe_pkg::*;

    // Pre-rotation stage: folds a vector in the left half plane over.
    logic   v0_reg, zero0_reg;
    coord_t x0_reg, y0_reg;
    angle_t z0_reg;

    logic   v_reg    [STAGES];
    logic   zero_reg [STAGES];
    coord_t x_reg    [STAGES];
    coord_t y_reg    [STAGES];
    angle_t z_reg    [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        zero0_reg <= (x_in == '0) && (y_in == '0);
        if (x_in < 0)
        begin
            x0_reg <= -x_in;
            y0_reg <= -y_in;
            z0_reg <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
        end
        else
        begin
            x0_reg <= x_in;
            y0_reg <= y_in;
            z0_reg <= '0;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        localparam angle_t ANG = atan_deg(i);
        coord_t xi, yi;
        angle_t zi;
        logic   vi, zri;

        if (i == 0)
        begin : g_first
            assign xi  = x0_reg;
            assign yi  = y0_reg;
            assign zi  = z0_reg;
            assign vi  = v0_reg;
            assign zri = zero0_reg;
        end
        else
        begin : g_rest
            assign xi  = x_reg[i-1];
            assign yi  = y_reg[i-1];
            assign zi  = z_reg[i-1];
            assign vi  = v_reg[i-1];
            assign zri = zero_reg[i-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else
            begin
                v_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            zero_reg[i] <= zri;
            if (yi >= 0)
            begin
                x_reg[i] <= xi + (yi >>> i);
                y_reg[i] <= yi - (xi >>> i);
                z_reg[i] <= zi + ANG;
            end
            else
            begin
                x_reg[i] <= xi - (yi >>> i);
                y_reg[i] <= yi + (xi >>> i);
                z_reg[i] <= zi - ANG;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign angle     = zero_reg[STAGES-1] ? '0 : z_reg[STAGES-1];

endmodule

// File: hdl/quaternion_to_euler_angles.sv
// Quaternion to Euler angle converter.
// Input channel: a beat is taken at each rising clock edge where start is high
// and busy is low. busy is always low, so a new quaternion (quat_w, quat_x,
// quat_y, quat_z, Q2.14 with 16384 as 1.0) may be offered every cycle.
// Output channel: done is high for exactly one cycle per input beat, and
// pitch_angle, roll_angle, yaw_angle (1/16 degree) and asin_clamped are valid
// in that cycle only. The receiver cannot hold results off, so it must take
// every result beat as it appears.
// Each beat passes, in order, through registers for the products, sums and
// the squared asin argument, the bit-per-stage square root that forms the
// cosine of the pitch, the CORDIC pre-rotation and micro-rotation stages, and
// a register for rounding and range clamping. Throughput is one beat per
// cycle; results leave in the order the quaternions arrived.
// Reset clears every valid bit in the pipeline, so no result beat appears
// until an input beat has traveled the full length after reset is released.
module quaternion_to_euler_angles #(
    parameter int CORDIC_STAGES = qtoe_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               done,
    output logic signed [11:0] pitch_angle,
    output logic signed [12:0] roll_angle,
    output logic signed [12:0] yaw_angle,
    output logic               asin_clamped
);
    import qtoe_pkg::*;

    localparam int LATENCY = 4 + ROOT_W + CORDIC_STAGES + 2;
    localparam angle_t PITCH_LIM = 27'sd1440;
    localparam angle_t TURN_LIM  = 27'sd2880;
    localparam angle_t HALF_LSB  = 27'sd2048;

    logic                front_valid;
    logic [RW-1:0]       rad;
    side_t               front_side;
    logic                root_valid;
    logic [ROOT_W-1:0]   root;
    side_t               root_side;
    coord_t              pitch_y, pitch_x;
    logic                pitch_valid, roll_valid, yaw_valid;
    angle_t              pitch_z, roll_z, yaw_z;
    angle_t              pitch_r, roll_r, yaw_r;

    // The clamp flag waits alongside the CORDIC pipelines.
    logic                clamp_line_reg [CORDIC_STAGES+1];

    logic                done_reg;
    logic signed [11:0]  pitch_reg;
    logic signed [12:0]  roll_reg, yaw_reg;
    logic                clamp_reg;

    assign busy = 1'b0;

    qtoe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .out_valid (front_valid),
        .rad       (rad),
        .side      (front_side)
    );

    qtoe_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .rad       (rad),
        .side_in   (front_side),
        .out_valid (root_valid),
        .root      (root),
        .side_out  (root_side)
    );

    // The pitch is atan2 of the sine against the square root of one minus its square.
    assign pitch_y = CW'(root_side.s);
    assign pitch_x = CW'({1'b0, root});

    qtoe_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .y_in      (pitch_y),
        .x_in      (pitch_x),
        .out_valid (pitch_valid),
        .angle     (pitch_z)
    );

    qtoe_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .y_in      (root_side.roll_y),
        .x_in      (root_side.roll_x),
        .out_valid (roll_valid),
        .angle     (roll_z)
    );

    qtoe_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (root_valid),
        .y_in      (root_side.yaw_y),
        .x_in      (root_side.yaw_x),
        .out_valid (yaw_valid),
        .angle     (yaw_z)
    );

    // Round to 1/16 degree with halves away from zero, then clamp to the range.
    always_comb
    begin
        if (pitch_z >= 0)
        begin
            pitch_r = (pitch_z + HALF_LSB) >>> 12;
        end
        else
        begin
            pitch_r = -((-pitch_z + HALF_LSB) >>> 12);
        end
        if (roll_z >= 0)
        begin
            roll_r = (roll_z + HALF_LSB) >>> 12;
        end
        else
        begin
            roll_r = -((-roll_z + HALF_LSB) >>> 12);
        end
        if (yaw_z >= 0)
        begin
            yaw_r = (yaw_z + HALF_LSB) >>> 12;
        end
        else
        begin
            yaw_r = -((-yaw_z + HALF_LSB) >>> 12);
        end
        if (pitch_r > PITCH_LIM)
        begin
            pitch_r = PITCH_LIM;
        end
        else if (pitch_r < -PITCH_LIM)
        begin
            pitch_r = -PITCH_LIM;
        end
        if (roll_r > TURN_LIM)
        begin
            roll_r = TURN_LIM;
        end
        else if (roll_r < -TURN_LIM)
        begin
            roll_r = -TURN_LIM;
        end
        if (yaw_r > TURN_LIM)
        begin
            yaw_r = TURN_LIM;
        end
        else if (yaw_r < -TURN_LIM)
        begin
            yaw_r = -TURN_LIM;
        end
    end

    always_ff @(posedge clk)
    begin
        clamp_line_reg[0] <= root_side.clamp;
        for (int k = 1; k <= CORDIC_STAGES; k++)
        begin
            clamp_line_reg[k] <= clamp_line_reg[k-1];
        end
        pitch_reg <= pitch_r[11:0];
        roll_reg  <= roll_r[12:0];
        yaw_reg   <= yaw_r[12:0];
        clamp_reg <= clamp_line_reg[CORDIC_STAGES];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pitch_valid;
        end
    end

    assign done         = done_reg;
    assign pitch_angle  = pitch_reg;
    assign roll_angle   = roll_reg;
    assign yaw_angle    = yaw_reg;
    assign asin_clamped = clamp_reg;

`ifndef SYNTHESIS
    // Every result beat traces back to an input beat a fixed latency earlier.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result beat without a matching input beat");

    // The three angle pipelines stay in lockstep.
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (pitch_valid == roll_valid) && (roll_valid == yaw_valid))
        else $error("angle pipelines out of step");

    // Delivered angles stay within their documented ranges.
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (pitch_angle <= 12'sd1440 && pitch_angle >= -12'sd1440))
        else $error("pitch out of range");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (roll_angle <= 13'sd2880 && roll_angle >= -13'sd2880
                  && yaw_angle <= 13'sd2880 && yaw_angle >= -13'sd2880))
        else $error("roll or yaw out of range");
`endif

endmodule
